FILE: src/snd_pkg.sv
// ============================================================================
// snd_pkg - shared types and constants for the stick normalizer
// Field widths, Q1.14 constants, register indexes and flag structs used
// by the top level and the pipelined divider.
// ============================================================================
package snd_pkg;

   // Field widths
   localparam int RAW_W  = 12;   // raw converter sample
   localparam int DZ_W   = 14;   // dead zone register
   localparam int FRAC_W = 14;   // Q1.14 fraction bits
   localparam int QUO_W  = 15;   // quotient bits, covers 0..16384
   localparam int MAG_W  = 15;   // normalized magnitude, 0..16384
   localparam int OUT_W  = 16;   // signed Q1.14 result
   localparam int LANES  = 2;    // horizontal and vertical axis

   // Quotient bits resolved per divider stage
   localparam int DIV_STEPS = 3;

   // 1.0 in Q1.14
   localparam logic [MAG_W-1:0] ONE_Q14 = 15'd16384;

   // Configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_X_MIN     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_X_CENTER  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_X_MAX     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_MIN     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_CENTER  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_MAX     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DZ_LEVEL  = 3'd6;

   // Per-axis flags riding along the span divider
   typedef struct packed {
      logic neg;    // sample below center
      logic sat;    // distance exceeds span, force 1.0
      logic zero;   // span of zero, force 0
   } nrm_flags_type;

   // Per-axis flags riding along the dead zone divider
   typedef struct packed {
      logic neg;    // result takes a minus sign
      logic under;  // magnitude inside the dead zone
   } dz_flags_type;

endpackage

FILE: src/snd_div_pipe.sv
// ============================================================================
// snd_div_pipe - pipelined restoring divider, two lanes
// Resolves QUO_W quotient bits, DIV_STEPS per register stage. The dividend
// tail bits and the quotient share one shift register per lane.
// ============================================================================
module snd_div_pipe #(
   parameter int W  = 12,   // divisor and remainder width
   parameter int SW = 1     // sideband width
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      in_valid,
   output logic                                      in_ready,
   input  logic [snd_pkg::LANES-1:0][W-1:0]          in_rem,
   input  logic [snd_pkg::LANES-1:0][snd_pkg::QUO_W-1:0] in_lq,
   input  logic [snd_pkg::LANES-1:0][W-1:0]          in_div,
   input  logic [SW-1:0]                             in_side,
   output logic                                      out_valid,
   input  logic                                      out_ready,
   output logic [snd_pkg::LANES-1:0][snd_pkg::QUO_W-1:0] out_quo,
   output logic [SW-1:0]                             out_side
);

   localparam int QW  = snd_pkg::QUO_W;
   localparam int SPS = snd_pkg::DIV_STEPS;
   localparam int NL  = snd_pkg::LANES;
   localparam int NST = (QW + SPS - 1) / SPS;

   logic [NST-1:0]           vld_ff;
   logic [NST:0]             rdy;
   logic [NL-1:0][W-1:0]     rem_ff [NST];
   logic [NL-1:0][W-1:0]     div_ff [NST];
   logic [NL-1:0][QW-1:0]    lq_ff  [NST];
   logic [SW-1:0]            side_ff [NST];

   assign rdy[NST] = out_ready;
   assign in_ready = rdy[0];

   for (genvar s = 0; s < NST; s++) begin : g_st
      logic                  src_vld;
      logic [NL-1:0][W-1:0]  src_rem;
      logic [NL-1:0][W-1:0]  src_div;
      logic [NL-1:0][QW-1:0] src_lq;
      logic [SW-1:0]         src_side;
      logic [NL-1:0][W-1:0]  rem_in;
      logic [NL-1:0][QW-1:0] lq_in;

      if (s == 0) begin : g_head
         assign src_vld  = in_valid;
         assign src_rem  = in_rem;
         assign src_div  = in_div;
         assign src_lq   = in_lq;
         assign src_side = in_side;
      end else begin : g_body
         assign src_vld  = vld_ff[s-1];
         assign src_rem  = rem_ff[s-1];
         assign src_div  = div_ff[s-1];
         assign src_lq   = lq_ff[s-1];
         assign src_side = side_ff[s-1];
      end

      assign rdy[s] = !vld_ff[s] || rdy[s+1];

      // shift in one dividend bit, subtract when it fits, shift in the
      // quotient bit
      always_comb begin
         logic [W:0] part;
         logic       qbit;
         rem_in = src_rem;
         lq_in  = src_lq;
         part   = '0;
         qbit   = 1'b0;
         for (int l = 0; l < NL; l++) begin
            for (int j = 0; j < SPS; j++) begin
               if (s * SPS + j < QW) begin
                  part = {rem_in[l], lq_in[l][QW-1]};
                  qbit = (part >= {1'b0, src_div[l]});
                  if (qbit) begin
                     part = part - {1'b0, src_div[l]};
                  end
                  rem_in[l] = part[W-1:0];
                  lq_in[l]  = {lq_in[l][QW-2:0], qbit};
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (rdy[s]) begin
            vld_ff[s] <= src_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[s] && src_vld) begin
            rem_ff[s]  <= rem_in;
            div_ff[s]  <= src_div;
            lq_ff[s]   <= lq_in;
            side_ff[s] <= src_side;
         end
      end
   end

   assign out_valid = vld_ff[NST-1];
   assign out_quo   = lq_ff[NST-1];
   assign out_side  = side_ff[NST-1];

endmodule

FILE: src/stick_normalize_deadzone.sv
// ============================================================================
// stick_normalize_deadzone - two-axis stick calibration with radial dead zone
// Clamps each raw axis sample to its calibrated range, scales the distance
// from center to signed Q1.14 and applies a rescaled dead zone.
// ============================================================================
// Stages up to rsp_valid: 3 front stages, 5 span divider stages, 2 middle
//   stages, 5 dead zone divider stages, 1 out; each divider resolves 3
//   quotient bits a stage. Throughput: one item per cycle while not stalled.
// Stalls back up stage by stage, so empty stages fill while a result waits.
// Reset: synchronous, clears all valid bits and loads the default calibration
//   (range 0..4095, center 2048, dead zone 2458).
module stick_normalize_deadzone (
   input  logic                            clock,
   input  logic                            reset,
   // input items
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [snd_pkg::RAW_W-1:0]       req_raw_x,
   input  logic [snd_pkg::RAW_W-1:0]       req_raw_y,
   // result items
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [snd_pkg::OUT_W-1:0] rsp_norm_x,
   output logic signed [snd_pkg::OUT_W-1:0] rsp_norm_y,
   // register writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [snd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [snd_pkg::DZ_W-1:0]        csr_wdata
);

   localparam int RW = snd_pkg::RAW_W;
   localparam int MW = snd_pkg::MAG_W;
   localparam int QW = snd_pkg::QUO_W;
   localparam int FW = snd_pkg::FRAC_W;
   localparam int OW = snd_pkg::OUT_W;
   localparam int NL = snd_pkg::LANES;
   localparam int DW = snd_pkg::DZ_W;

   // -------------------------------------------------------------------------
   // Calibration registers, lane 0 is horizontal, lane 1 vertical
   // -------------------------------------------------------------------------
   logic [NL-1:0][RW-1:0] min_ff;
   logic [NL-1:0][RW-1:0] ctr_ff;
   logic [NL-1:0][RW-1:0] max_ff;
   logic [DW-1:0]         dz_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= {NL{12'd0}};
         ctr_ff <= {NL{12'd2048}};
         max_ff <= {NL{12'd4095}};
         dz_ff  <= 14'd2458;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            snd_pkg::CSR_X_MIN:     min_ff[0] <= csr_wdata[RW-1:0];
            snd_pkg::CSR_X_CENTER:  ctr_ff[0] <= csr_wdata[RW-1:0];
            snd_pkg::CSR_X_MAX:     max_ff[0] <= csr_wdata[RW-1:0];
            snd_pkg::CSR_Y_MIN:     min_ff[1] <= csr_wdata[RW-1:0];
            snd_pkg::CSR_Y_CENTER:  ctr_ff[1] <= csr_wdata[RW-1:0];
            snd_pkg::CSR_Y_MAX:     max_ff[1] <= csr_wdata[RW-1:0];
            snd_pkg::CSR_DZ_LEVEL:  dz_ff     <= csr_wdata;
            default: ;   // drop writes to unused indexes
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Stage readiness: a stage takes new data when empty or when its
   // successor takes its current item.
   // -------------------------------------------------------------------------
   logic p1_rdy, p2_rdy, p3_rdy, p4_rdy, p5_rdy, rsp_rdy;
   logic d1_in_ready, d2_in_ready;

   logic p1_vld_ff, p2_vld_ff, p3_vld_ff, p4_vld_ff, p5_vld_ff, rsp_valid_ff;

   assign rsp_rdy   = !rsp_valid_ff || !rsp_stall;
   assign p5_rdy    = !p5_vld_ff || d2_in_ready;
   assign p4_rdy    = !p4_vld_ff || p5_rdy;
   assign p3_rdy    = !p3_vld_ff || d1_in_ready;
   assign p2_rdy    = !p2_vld_ff || p3_rdy;
   assign p1_rdy    = !p1_vld_ff || p2_rdy;
   assign req_stall = !p1_rdy;

   // -------------------------------------------------------------------------
   // P1: clamp to the calibrated range. Upper clamp first, lower clamp last,
   // so a minimum above the maximum wins.
   // -------------------------------------------------------------------------
   logic [NL-1:0][RW-1:0] p1_v_in, p1_v_ff;
   logic [NL-1:0][RW-1:0] raw;

   assign raw[0] = req_raw_x;
   assign raw[1] = req_raw_y;

   always_comb begin
      for (int l = 0; l < NL; l++) begin
         p1_v_in[l] = (raw[l] < max_ff[l]) ? raw[l] : max_ff[l];
         if (p1_v_in[l] < min_ff[l]) begin
            p1_v_in[l] = min_ff[l];
         end
      end
   end

   // -------------------------------------------------------------------------
   // P2: distance from center and span on that side; a negative span counts
   // as zero span.
   // -------------------------------------------------------------------------
   logic [NL-1:0][RW-1:0] p2_num_in, p2_num_ff;
   logic [NL-1:0][RW-1:0] p2_span_in, p2_span_ff;
   logic [NL-1:0]         p2_neg_in, p2_neg_ff;

   always_comb begin
      for (int l = 0; l < NL; l++) begin
         p2_neg_in[l] = (p1_v_ff[l] < ctr_ff[l]);
         if (!p2_neg_in[l]) begin
            p2_num_in[l]  = p1_v_ff[l] - ctr_ff[l];
            p2_span_in[l] = (max_ff[l] > ctr_ff[l]) ? max_ff[l] - ctr_ff[l] : '0;
         end else begin
            p2_num_in[l]  = ctr_ff[l] - p1_v_ff[l];
            p2_span_in[l] = (ctr_ff[l] > min_ff[l]) ? ctr_ff[l] - min_ff[l] : '0;
         end
      end
   end

   // -------------------------------------------------------------------------
   // P3: flag saturation (distance above span means above 1.0) and set up
   // the division of distance * 2^14 by span. The top remainder is
   // distance / 2, which stays below span whenever the result fits.
   // -------------------------------------------------------------------------
   logic [NL-1:0][RW-1:0]              p3_rem_in, p3_rem_ff;
   logic [NL-1:0][QW-1:0]              p3_lq_in, p3_lq_ff;
   logic [NL-1:0][RW-1:0]              p3_span_ff;
   snd_pkg::nrm_flags_type [NL-1:0]    p3_flags_in, p3_flags_ff;

   always_comb begin
      for (int l = 0; l < NL; l++) begin
         p3_rem_in[l]         = {1'b0, p2_num_ff[l][RW-1:1]};
         p3_lq_in[l]          = {p2_num_ff[l][0], {FW{1'b0}}};
         p3_flags_in[l].neg   = p2_neg_ff[l];
         p3_flags_in[l].sat   = (p2_num_ff[l] > p2_span_ff[l]);
         p3_flags_in[l].zero  = (p2_span_ff[l] == '0);
      end
   end

   // -------------------------------------------------------------------------
   // Span divider
   // -------------------------------------------------------------------------
   logic                            d1_valid;
   logic [NL-1:0][QW-1:0]           d1_quo;
   snd_pkg::nrm_flags_type [NL-1:0] d1_flags;

   snd_div_pipe #(
      .W  (RW),
      .SW ($bits(snd_pkg::nrm_flags_type) * NL)
   ) u_div_span (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p3_vld_ff),
      .in_ready  (d1_in_ready),
      .in_rem    (p3_rem_ff),
      .in_lq     (p3_lq_ff),
      .in_div    (p3_span_ff),
      .in_side   (p3_flags_ff),
      .out_valid (d1_valid),
      .out_ready (p4_rdy),
      .out_quo   (d1_quo),
      .out_side  (d1_flags)
   );

   // -------------------------------------------------------------------------
   // P4: magnitude; zero span gives 0, overrange gives 1.0
   // -------------------------------------------------------------------------
   logic [NL-1:0][MW-1:0] p4_mag_in, p4_mag_ff;
   logic [NL-1:0]         p4_neg_in, p4_neg_ff;

   always_comb begin
      for (int l = 0; l < NL; l++) begin
         p4_neg_in[l] = d1_flags[l].neg;
         priority if (d1_flags[l].zero) begin
            p4_mag_in[l] = '0;
         end else if (d1_flags[l].sat) begin
            p4_mag_in[l] = snd_pkg::ONE_Q14;
         end else begin
            p4_mag_in[l] = d1_quo[l];
         end
      end
   end

   // -------------------------------------------------------------------------
   // P5: dead zone. Set up (mag - dz) * 2^14 / (1.0 - dz). Since mag never
   // exceeds 1.0 the quotient never exceeds 1.0 either.
   // -------------------------------------------------------------------------
   logic [NL-1:0][MW-1:0]          p5_rem_in, p5_rem_ff;
   logic [NL-1:0][QW-1:0]          p5_lq_in, p5_lq_ff;
   logic [MW-1:0]                  p5_div_in, p5_div_ff;
   snd_pkg::dz_flags_type [NL-1:0] p5_flags_in, p5_flags_ff;
   logic [NL-1:0][MW-1:0]          p5_dist;

   assign p5_div_in = snd_pkg::ONE_Q14 - {1'b0, dz_ff};

   always_comb begin
      for (int l = 0; l < NL; l++) begin
         p5_dist[l]           = p4_mag_ff[l] - {1'b0, dz_ff};
         p5_rem_in[l]         = {1'b0, p5_dist[l][MW-1:1]};
         p5_lq_in[l]          = {p5_dist[l][0], {FW{1'b0}}};
         p5_flags_in[l].neg   = p4_neg_ff[l];
         p5_flags_in[l].under = (p4_mag_ff[l] < {1'b0, dz_ff});
      end
   end

   // -------------------------------------------------------------------------
   // Dead zone divider
   // -------------------------------------------------------------------------
   logic                           d2_valid;
   logic [NL-1:0][QW-1:0]          d2_quo;
   snd_pkg::dz_flags_type [NL-1:0] d2_flags;

   snd_div_pipe #(
      .W  (MW),
      .SW ($bits(snd_pkg::dz_flags_type) * NL)
   ) u_div_dz (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p5_vld_ff),
      .in_ready  (d2_in_ready),
      .in_rem    (p5_rem_ff),
      .in_lq     (p5_lq_ff),
      .in_div    ({NL{p5_div_ff}}),
      .in_side   (p5_flags_ff),
      .out_valid (d2_valid),
      .out_ready (rsp_rdy),
      .out_quo   (d2_quo),
      .out_side  (d2_flags)
   );

   // -------------------------------------------------------------------------
   // Output register: drop magnitudes inside the dead zone, restore the sign
   // -------------------------------------------------------------------------
   logic [NL-1:0][OW-1:0] rsp_norm_in, rsp_norm_ff;
   logic [NL-1:0][MW-1:0] out_mag;

   always_comb begin
      for (int l = 0; l < NL; l++) begin
         out_mag[l] = d2_flags[l].under ? '0 : d2_quo[l];
         if (d2_flags[l].neg) begin
            rsp_norm_in[l] = {OW{1'b0}} - {1'b0, out_mag[l]};
         end else begin
            rsp_norm_in[l] = {1'b0, out_mag[l]};
         end
      end
   end

   // -------------------------------------------------------------------------
   // Valid bits
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff    <= 1'b0;
         p2_vld_ff    <= 1'b0;
         p3_vld_ff    <= 1'b0;
         p4_vld_ff    <= 1'b0;
         p5_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (p1_rdy)  p1_vld_ff    <= req_valid;
         if (p2_rdy)  p2_vld_ff    <= p1_vld_ff;
         if (p3_rdy)  p3_vld_ff    <= p2_vld_ff;
         if (p4_rdy)  p4_vld_ff    <= d1_valid;
         if (p5_rdy)  p5_vld_ff    <= p4_vld_ff;
         if (rsp_rdy) rsp_valid_ff <= d2_valid;
      end
   end

   // -------------------------------------------------------------------------
   // Payload registers: advance only with a valid item
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (p1_rdy && req_valid) begin
         p1_v_ff <= p1_v_in;
      end
      if (p2_rdy && p1_vld_ff) begin
         p2_num_ff  <= p2_num_in;
         p2_span_ff <= p2_span_in;
         p2_neg_ff  <= p2_neg_in;
      end
      if (p3_rdy && p2_vld_ff) begin
         p3_rem_ff   <= p3_rem_in;
         p3_lq_ff    <= p3_lq_in;
         p3_span_ff  <= p2_span_ff;
         p3_flags_ff <= p3_flags_in;
      end
      if (p4_rdy && d1_valid) begin
         p4_mag_ff <= p4_mag_in;
         p4_neg_ff <= p4_neg_in;
      end
      if (p5_rdy && p4_vld_ff) begin
         p5_rem_ff   <= p5_rem_in;
         p5_lq_ff    <= p5_lq_in;
         p5_div_ff   <= p5_div_in;
         p5_flags_ff <= p5_flags_in;
      end
      if (rsp_rdy && d2_valid) begin
         rsp_norm_ff <= rsp_norm_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_norm_x = rsp_norm_ff[0];
   assign rsp_norm_y = rsp_norm_ff[1];

endmodule

FILE: src/snd_checker.sv
// ============================================================================
// snd_checker - port-level checks for the stick normalizer
// Tracks items in flight and checks result range, ordering of reset and
// the result handshake.
// ============================================================================
module snd_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic signed [snd_pkg::OUT_W-1:0] rsp_norm_x,
   input logic signed [snd_pkg::OUT_W-1:0] rsp_norm_y
);

   localparam int DEPTH = 16;   // item slots from input to output register
   localparam int CW    = 6;

   logic [CW-1:0] cnt_ff, cnt_in;
   logic          acc_req, acc_rsp;

   assign acc_req = req_valid && !req_stall;
   assign acc_rsp = rsp_valid && !rsp_stall;
   assign cnt_in  = cnt_ff + CW'(acc_req) - CW'(acc_rsp);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_norm_x) && $stable(rsp_norm_y))
      else $error("stalled result changed");

   // never show a result that no accepted item explains
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> cnt_ff != '0)
      else $error("result without an accepted item");

   // pipeline never holds more items than it has slots
   a_depth: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DEPTH))
      else $error("more items in flight than pipeline slots");

   // results stay within -1.0 .. 1.0
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_norm_x >= -16'sd16384 && rsp_norm_x <= 16'sd16384 &&
                    rsp_norm_y >= -16'sd16384 && rsp_norm_y <= 16'sd16384)
      else $error("normalized result out of range");

   // reset empties the pipeline
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind stick_normalize_deadzone snd_checker u_snd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_norm_x (rsp_norm_x),
   .rsp_norm_y (rsp_norm_y)
);
